[rtl/median7_reflect_row_filter_assert.svh]
// Assertion macros for the seven-tap median row filter.
// Included by the top level; no other dependencies.
`ifndef MEDIAN7_REFLECT_ROW_FILTER_ASSERT_SVH
`define MEDIAN7_REFLECT_ROW_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MRF_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, checked outside reset
`define MRF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[rtl/mrf_pkg.sv]
// Shared types, constants and the window tap mapping for the median row filter.
// No dependencies.
package mrf_pkg;

   localparam int WINDOW     = 7;
   localparam int HALF       = WINDOW / 2;
   localparam int SAMPLE_W   = 16;
   localparam int MAX_ROW    = 2048;
   localparam int MIN_ROW    = HALF + 1;
   localparam int POS_W      = 11;
   localparam int LEN_W      = 12;
   localparam int TAP_W      = $clog2(WINDOW);
   localparam int RANK_W     = $clog2(WINDOW);
   localparam int BACK_W     = $clog2(HALF + 1);
   // position saturates here; mirroring only looks at small positions
   localparam int PSAT_W     = 4;
   localparam int PSAT_MAX   = (1 << PSAT_W) - 1;
   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(1500);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type window_type [WINDOW];

   typedef struct packed {
      logic              emit;     // item yields at least one result
      logic              at_end;   // item closes the row
      logic [PSAT_W-1:0] pos_sat;  // position of the item, saturated
   } row_status_type;

   // History slot feeding window tap 'tap' of the result 'back' places behind
   // the newest position, with mirroring at both row ends.
   function automatic logic [TAP_W-1:0] tap_sel(input logic [PSAT_W-1:0] pos,
                                                input logic [BACK_W-1:0] back,
                                                input int tap,
                                                input logic at_end);
      int p;
      int idx;
      int k;
      p   = int'(pos);
      idx = p + tap - HALF - int'(back);
      if (idx < 0) idx = -idx;
      if (at_end && (idx >= p + 1)) idx = 2 * p - idx;
      k = p - idx;
      if (k < 0) k = 0;
      if (k > WINDOW - 1) k = WINDOW - 1;
      return TAP_W'(k);
   endfunction

endpackage

[rtl/median7_reflect_row_filter.sv]
// Seven-tap median row filter with mirrored row edges.
// A sample's result passes the window snapshot register, then the result register.
// Throughput: one sample per cycle unless the result path stalls; a row's last sample
// issues four results in turn from one window snapshot, overlapping the next row's
// first three samples. Synchronous reset clears control, row length to 1500.
// Depends on mrf_pkg, mrf_history, mrf_rowctl, mrf_median and the assert header.
`include "median7_reflect_row_filter_assert.svh"

module median7_reflect_row_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mrf_pkg::sample_type        req_sample,
   input  logic                       req_block_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mrf_pkg::sample_type        rsp_filtered,
   output logic                       rsp_row_end,
   output logic                       rsp_block_last,
   input  logic                       csr_write_enable,
   input  logic [mrf_pkg::LEN_W-1:0]  csr_write_data
);
   import mrf_pkg::*;

   logic [LEN_W-1:0]   row_length_ff;
   row_status_type     row_status;
   window_type         hist_next;
   logic               accept;
   logic               load;

   // window snapshot stage
   logic               snap_valid_ff;
   window_type         snap_hist_ff;
   logic [PSAT_W-1:0]  snap_pos_ff;
   logic               snap_end_ff;
   logic               snap_blk_ff;
   logic [BACK_W-1:0]  snap_back_ff;
   logic               slot_last;
   logic               slot_adv;
   logic               slot_free;
   window_type         taps;
   sample_type         median;

   // result register
   logic               rsp_valid_ff;
   sample_type         rsp_filtered_ff;
   logic               rsp_row_end_ff;
   logic               rsp_block_last_ff;
   logic               out_free;

   // row length register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
      end else if (csr_write_enable) begin
         row_length_ff <= csr_write_data;
      end
   end

   mrf_rowctl u_rowctl (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .row_length (row_length_ff),
      .status     (row_status)
   );

   mrf_history u_history (
      .clock     (clock),
      .shift     (accept),
      .sample    (req_sample),
      .hist_next (hist_next)
   );

   // handshake: samples without results never wait for the snapshot stage
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_last = !snap_end_ff || (snap_back_ff == '0);
   assign slot_adv  = snap_valid_ff && out_free;
   assign slot_free = !snap_valid_ff || (slot_adv && slot_last);
   assign req_ready = !row_status.emit || slot_free;
   assign accept    = req_valid && req_ready;
   assign load      = accept && row_status.emit;

   // snapshot control
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         snap_back_ff  <= '0;
      end else if (load) begin
         snap_valid_ff <= 1'b1;
         snap_back_ff  <= BACK_W'(HALF);
      end else if (slot_adv) begin
         if (slot_last) begin
            snap_valid_ff <= 1'b0;
         end else begin
            snap_back_ff <= snap_back_ff - BACK_W'(1);
         end
      end
   end

   // snapshot payload
   always_ff @(posedge clock) begin
      if (load) begin
         snap_hist_ff <= hist_next;
         snap_pos_ff  <= row_status.pos_sat;
         snap_end_ff  <= row_status.at_end;
         snap_blk_ff  <= req_block_end;
      end
   end

   // gather the mirrored window for the current result
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         taps[i] = snap_hist_ff[tap_sel(snap_pos_ff, snap_back_ff, i, snap_end_ff)];
      end
   end

   mrf_median u_median (
      .taps   (taps),
      .median (median)
   );

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (slot_adv) begin
         rsp_filtered_ff   <= median;
         rsp_row_end_ff    <= snap_end_ff && (snap_back_ff == '0);
         rsp_block_last_ff <= snap_end_ff && (snap_back_ff == '0) && snap_blk_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filtered_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_block_last = rsp_block_last_ff;

   // checks
   `MRF_ASSERT_NOW(a_block_last_on_row_end, clock, reset, rsp_valid_ff && rsp_block_last_ff, rsp_row_end_ff, "block end mark without row end mark")
   `MRF_ASSERT_NEXT(a_row_restart, clock, reset, accept && row_status.at_end, row_status.pos_sat == '0, "row position not cleared after row end")
   `MRF_ASSERT_NEXT(a_burst_continues, clock, reset, slot_adv && !slot_last && !load, snap_valid_ff, "row end burst cut short")
   `MRF_ASSERT_NEXT(a_slot_to_output, clock, reset, slot_adv, rsp_valid_ff, "issued slot did not reach the result register")

endmodule

[rtl/mrf_history.sv]
// Sample history shift register, newest sample first.
// Depends on mrf_pkg.
module mrf_history (
   input  logic               clock,
   input  logic               shift,
   input  mrf_pkg::sample_type sample,
   output mrf_pkg::window_type hist_next
);
   import mrf_pkg::*;

   window_type hist_ff;

   // shifted view including the incoming sample
   always_comb begin
      hist_next[0] = sample;
      for (int i = 1; i < WINDOW; i++) begin
         hist_next[i] = hist_ff[i-1];
      end
   end

   // contents are only read once written within the row: no reset
   always_ff @(posedge clock) begin
      if (shift) begin
         hist_ff <= hist_next;
      end
   end

endmodule

[rtl/mrf_rowctl.sv]
// Row position counter and row end detection.
// Depends on mrf_pkg.
module mrf_rowctl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [mrf_pkg::LEN_W-1:0]    row_length,
   output mrf_pkg::row_status_type      status
);
   import mrf_pkg::*;

   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic [LEN_W-1:0] len_clamped;
   logic [LEN_W-1:0] pos_plus;

   // clamp the programmed length to the supported range
   always_comb begin
      if (row_length < LEN_W'(MIN_ROW)) begin
         len_clamped = LEN_W'(MIN_ROW);
      end else if (row_length > LEN_W'(MAX_ROW)) begin
         len_clamped = LEN_W'(MAX_ROW);
      end else begin
         len_clamped = row_length;
      end
   end

   assign pos_plus = {1'b0, position_ff} + LEN_W'(1);

   always_comb begin
      status.at_end  = (pos_plus >= len_clamped);
      status.emit    = status.at_end || (position_ff >= POS_W'(HALF));
      status.pos_sat = (position_ff > POS_W'(PSAT_MAX)) ? PSAT_W'(PSAT_MAX)
                                                         : position_ff[PSAT_W-1:0];
      position_in    = status.at_end ? '0 : pos_plus[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (advance) begin
         position_ff <= position_in;
      end
   end

endmodule

[rtl/mrf_median.sv]
// Seven-input median by rank counting, purely combinational.
// Depends on mrf_pkg.
module mrf_median (
   input  mrf_pkg::window_type taps,
   output mrf_pkg::sample_type median
);
   import mrf_pkg::*;

   logic [RANK_W-1:0] rank [WINDOW];

   // rank of each tap; ties broken by tap order
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW; j++) begin
            if (j != i) begin
               if ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   // exactly one tap holds the middle rank
   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (rank[i] == RANK_W'(HALF)) begin
            median = taps[i];
         end
      end
   end

endmodule

[tb/median7_reflect_row_filter_checker.sv]
`timescale 1ns / 100ps
// Checker for the seven-tap median row filter: keeps its own row length copy,
// predicts the results of every input transfer and compares them in order.
// Depends on mrf_pkg for the sample type and the window constants.

module median7_reflect_row_filter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  mrf_pkg::sample_type               req_sample,
   input  logic                              req_block_end,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  mrf_pkg::sample_type               rsp_filtered,
   input  logic                              rsp_row_end,
   input  logic                              rsp_block_last,
   input  logic                              csr_write_enable,
   input  logic [mrf_pkg::LEN_W-1:0]         csr_write_data,
   output int                                mismatch_count,
   output int                                awaited_count
);

   typedef struct packed {
      mrf_pkg::sample_type filtered;
      logic                row_end;
      logic                block_last;
   } median_result_type;

   // newest sample in slot 0
   mrf_pkg::sample_type       recent [mrf_pkg::WINDOW];
   logic [mrf_pkg::LEN_W-1:0] row_length_copy;
   int                        row_pos;
   median_result_type         awaited_results [$];

   // Median of the window centred on row index 'centre', edges mirrored
   // about the end samples of a row of 'row_len', 'newest' being the latest index
   function automatic mrf_pkg::sample_type mirrored_median(input int centre,
                                                           input int row_len,
                                                           input int newest);
      mrf_pkg::sample_type taps [mrf_pkg::WINDOW];
      mrf_pkg::sample_type held;
      int idx;
      int slot;
      int i;
      int j;
      for (i = 0; i < mrf_pkg::WINDOW; i++) begin
         idx = centre + i - mrf_pkg::HALF;
         if (idx < 0) idx = -idx;
         if (idx >= row_len) idx = 2 * (row_len - 1) - idx;
         slot = newest - idx;
         if (slot < 0) slot = 0;
         if (slot > mrf_pkg::WINDOW - 1) slot = mrf_pkg::WINDOW - 1;
         taps[i] = recent[slot];
      end
      // insertion sort, signed order
      for (i = 1; i < mrf_pkg::WINDOW; i++) begin
         held = taps[i];
         j = i;
         while (j > 0 && taps[j-1] > held) begin
            taps[j] = taps[j-1];
            j--;
         end
         taps[j] = held;
      end
      return taps[mrf_pkg::HALF];
   endfunction

   // Append one expectation at the tail of the queue
   task automatic enqueue_result(input median_result_type item);
      awaited_results.insert(awaited_results.size(), item);
   endtask

   // Take one sample into the history and queue the results it causes
   task automatic absorb_sample(input mrf_pkg::sample_type value, input logic block_end);
      int                eff_len;
      int                first;
      int                centre;
      int                i;
      median_result_type item;
      eff_len = int'(row_length_copy);
      if (eff_len < mrf_pkg::MIN_ROW) eff_len = mrf_pkg::MIN_ROW;
      if (eff_len > mrf_pkg::MAX_ROW) eff_len = mrf_pkg::MAX_ROW;
      for (i = mrf_pkg::WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = value;
      if (row_pos + 1 < eff_len) begin
         if (row_pos >= mrf_pkg::HALF) begin
            item.filtered   = mirrored_median(row_pos - mrf_pkg::HALF, eff_len, row_pos);
            item.row_end    = 1'b0;
            item.block_last = 1'b0;
            enqueue_result(item);
         end
         row_pos++;
      end else begin
         // row closes here: flush the trailing positions, mirrored about this one
         first = (row_pos >= mrf_pkg::HALF) ? row_pos - mrf_pkg::HALF : 0;
         for (centre = first; centre <= row_pos; centre++) begin
            item.filtered   = mirrored_median(centre, row_pos + 1, row_pos);
            item.row_end    = (centre == row_pos);
            item.block_last = (centre == row_pos) && block_end;
            enqueue_result(item);
         end
         row_pos = 0;
      end
   endtask

   // Compare one result transfer with the oldest expectation
   task automatic check_result();
      median_result_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result: filtered %0d row_end %0b block_last %0b",
                rsp_filtered, rsp_row_end, rsp_block_last);
         mismatch_count++;
      end else begin
         want = awaited_results.pop_front();
         if (rsp_filtered !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered, rsp_filtered);
            mismatch_count++;
         end
         if (rsp_row_end !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, rsp_row_end);
            mismatch_count++;
         end
         if (rsp_block_last !== want.block_last) begin
            $error("block_last: expected %0b, actual %0b", want.block_last, rsp_block_last);
            mismatch_count++;
         end
      end
   endtask

   // Watch both channels and the register port at every rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mrf_pkg::WINDOW; i++) recent[i] = '0;
         row_pos         = 0;
         row_length_copy = mrf_pkg::ROW_LENGTH_RESET;
         awaited_results.delete();
         mismatch_count  = 0;
      end else begin
         if (req_valid && req_ready) absorb_sample(req_sample, req_block_end);
         if (rsp_valid && rsp_ready) check_result();
         if (csr_write_enable) row_length_copy = csr_write_data;
      end
      awaited_count = awaited_results.size();
   end

endmodule

[tb/median7_reflect_row_filter_test.sv]
`timescale 1ns / 100ps
// Top of the median row filter testbench: clock, reset, stimulus and verdict.
// Depends on mrf_pkg, the filter RTL and median7_reflect_row_filter_checker.

module median7_reflect_row_filter_test;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RANDOM_ITEMS    = 430;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int WATCHDOG_CYCLES = 400000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [15:0]        req_sample;
   logic                      req_block_end;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [15:0]        rsp_filtered;
   logic                      rsp_row_end;
   logic                      rsp_block_last;
   logic                      csr_write_enable;
   logic [mrf_pkg::LEN_W-1:0] csr_write_data;

   int   mismatch_count;
   int   awaited_count;

   // sender state
   bit   gaps_on;
   int   burst_left;
   int   row_fill;   // samples of the current row sent so far
   int   cur_len;    // effective row length
   logic hold_off_req;

   median7_reflect_row_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered     (rsp_filtered),
      .rsp_row_end      (rsp_row_end),
      .rsp_block_last   (rsp_block_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   median7_reflect_row_filter_checker CHECK (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered     (rsp_filtered),
      .rsp_row_end      (rsp_row_end),
      .rsp_block_last   (rsp_block_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   initial begin
      #(WATCHDOG_CYCLES * CLOCK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

   // Receiver: stall duty changes every few cycles, plus one long hold-off on request
   initial begin
      int  seg_left;
      int  duty;
      bit  start_hold;
      rsp_ready = 1'b0;
      seg_left  = 0;
      duty      = 100;
      forever begin
         @(posedge clock);
         start_hold = hold_off_req;
         @(negedge clock);
         if (start_hold) begin
            hold_off_req = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(5, 60);
            case ($urandom_range(0, 3))
               0: begin
                  duty = 100;
               end
               1: begin
                  duty = 70;
               end
               2: begin
                  duty = 40;
               end
               default: begin
                  duty = 15;
               end
            endcase
         end
         seg_left--;
         rsp_ready = ($urandom_range(1, 100) <= duty);
      end
   end

   // Stop offering and wait until every expected result has been taken
   task automatic idle_until_drained();
      req_valid = 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_row_length(input int value);
      idle_until_drained();
      csr_write_enable = 1'b1;
      csr_write_data   = value[mrf_pkg::LEN_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      cur_len = (value < mrf_pkg::MIN_ROW) ? mrf_pkg::MIN_ROW :
                (value > mrf_pkg::MAX_ROW) ? mrf_pkg::MAX_ROW : value;
   endtask

   // One input transfer, preceded by a random gap at the end of a burst
   task automatic send_sample(input int value, input logic block_end);
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      req_valid     = 1'b1;
      req_sample    = value[mrf_pkg::SAMPLE_W-1:0];
      req_block_end = block_end;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      row_fill = (row_fill + 1 >= cur_len) ? 0 : row_fill + 1;
   endtask

   // 0: full range, 1: small values with many ties, 2: extremes only
   function automatic int random_sample(input int style);
      case (style)
         0: return int'($urandom_range(0, 65535));
         1: return int'($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 3))
               0: return -32768;
               1: return 32767;
               2: return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   // block end mostly on a row's last sample, now and then a stray one
   function automatic logic pick_block_end();
      if (row_fill + 1 >= cur_len) return ($urandom_range(0, 3) != 0);
      return ($urandom_range(0, 24) == 0);
   endfunction

   // Stimulus and verdict
   initial begin
      int items_sent;
      int count;
      int style;
      int pick;
      int len;
      int i;
      bit hold_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_block_end    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hold_off_req     = 1'b0;
      gaps_on          = 1'b1;
      burst_left       = 0;
      row_fill         = 0;
      cur_len          = 1500;
      items_sent       = 0;
      hold_done        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: shortest row with extreme values
      write_row_length(4);
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
      send_sample(0, 1'b0);
      send_sample(-1, 1'b1);
      // length zero acts as the minimum; stray block end on the first sample
      write_row_length(0);
      send_sample(-32768, 1'b1);
      send_sample(-32768, 1'b0);
      send_sample(32767, 1'b0);
      send_sample(1, 1'b1);
      // length just below the minimum
      write_row_length(3);
      send_sample(5, 1'b0);
      send_sample(-5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(-5, 1'b0);
      // a full window with mirroring at both ends
      write_row_length(7);
      send_sample(7, 1'b0);
      send_sample(1, 1'b0);
      send_sample(6, 1'b0);
      send_sample(2, 1'b0);
      send_sample(5, 1'b0);
      send_sample(3, 1'b0);
      send_sample(4, 1'b1);
      // longest register value, then shortened mid-row so that the next sample closes the row
      write_row_length(4095);
      send_sample(100, 1'b0);
      send_sample(-100, 1'b0);
      send_sample(50, 1'b0);
      write_row_length(4);
      send_sample(-50, 1'b1);

      // Random phases, mostly short rows; lengths change mid-row as they fall
      while (items_sent < RANDOM_ITEMS) begin
         if (!hold_done && items_sent >= 150) begin
            // receiver holds off while the sender keeps offering
            write_row_length(6);
            hold_off_req = 1'b1;
            gaps_on      = 1'b0;
            for (i = 0; i < 40; i++) send_sample(random_sample(0), pick_block_end());
            gaps_on    = 1'b1;
            hold_done  = 1'b1;
            items_sent += 40;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      len = $urandom_range(4, 10);
            else if (pick < 72) len = $urandom_range(11, 40);
            else if (pick < 84) len = $urandom_range(0, 3);
            else if (pick < 89) len = mrf_pkg::MAX_ROW;
            else if (pick < 94) len = 4095;
            else                len = $urandom_range(41, 200);
            write_row_length(len);
            style = $urandom_range(0, 2);
            count = $urandom_range(5, 50);
            for (i = 0; i < count; i++) send_sample(random_sample(style), pick_block_end());
            items_sent += count;
         end
      end

      // Close the open row
      write_row_length(4);
      while (row_fill != 0) send_sample(random_sample(0), 1'b0);

      idle_until_drained();
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
